@@ sv/aluq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aluq_pkg;

  localparam int FRAC_BITS = 8;
  localparam int WORD_W    = 16;
  localparam int NUM_W     = WORD_W + FRAC_BITS;
  localparam int CMD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_MUL  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DIV  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd2;

  localparam logic [NUM_W-1:0] Q_ONE = NUM_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_DIV,
    KIND_STEP
  } kind_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [WORD_W-1:0] res;
    logic              err;
    logic [WORD_W-1:0] rem;
    logic [NUM_W-1:0]  num;
    logic [WORD_W-1:0] den;
    logic [NUM_W-1:0]  quo;
  } cell_t;

endpackage

`default_nettype wire

@@ sv/aluq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aluq_front (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire                          in_valid,
  input  wire  [aluq_pkg::CMD_W-1:0]   cmd,
  input  wire  [aluq_pkg::WORD_W-1:0]  operand_a,
  input  wire  [aluq_pkg::WORD_W-1:0]  operand_b,
  input  wire  [aluq_pkg::WORD_W-1:0]  operand_c,
  output aluq_pkg::cell_t              q
);

  logic [2*aluq_pkg::WORD_W-1:0] prod;
  logic [aluq_pkg::WORD_W-1:0]   diff_ca;
  logic [aluq_pkg::WORD_W-1:0]   diff_ba;
  aluq_pkg::cell_t               d;

  assign prod    = operand_a * operand_b;
  assign diff_ca = operand_c - operand_a;
  assign diff_ba = operand_b - operand_a;

  always_comb begin
    d       = '0;
    d.valid = in_valid;
    d.kind  = aluq_pkg::KIND_PASS;
    d.err   = 1'b1;
    case (cmd)
      aluq_pkg::CMD_MUL: begin
        d.res = prod[aluq_pkg::FRAC_BITS +: aluq_pkg::WORD_W];
        d.err = |(prod >> (aluq_pkg::FRAC_BITS + aluq_pkg::WORD_W));
      end
      aluq_pkg::CMD_DIV: begin
        if (operand_b == '0) begin
          d.res = '1;
        end else begin
          d.kind = aluq_pkg::KIND_DIV;
          d.err  = 1'b0;
          d.num  = {operand_a, aluq_pkg::FRAC_BITS'(0)};
          d.den  = operand_b;
        end
      end
      aluq_pkg::CMD_STEP: begin
        if (operand_b <= operand_a) begin
          d.res = '0;
        end else if (operand_c <= operand_a) begin
          d.res = '0;
          d.err = 1'b0;
        end else begin
          d.kind = aluq_pkg::KIND_STEP;
          d.err  = 1'b0;
          d.num  = {diff_ca, aluq_pkg::FRAC_BITS'(0)};
          d.den  = diff_ba;
        end
      end
      default: begin
        d.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

@@ sv/aluq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aluq_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   en,
  input  wire aluq_pkg::cell_t  d,
  output aluq_pkg::cell_t       q
);

  logic [aluq_pkg::WORD_W:0] rem_sh;
  logic [aluq_pkg::WORD_W:0] diff;
  logic                      ge;
  aluq_pkg::cell_t           nxt;

  // One restoring division step: bring down the next numerator bit.
  assign rem_sh = {d.rem, d.num[aluq_pkg::NUM_W-1]};
  assign diff   = rem_sh - {1'b0, d.den};
  assign ge     = ~diff[aluq_pkg::WORD_W];

  always_comb begin
    nxt     = d;
    nxt.rem = ge ? diff[aluq_pkg::WORD_W-1:0] : rem_sh[aluq_pkg::WORD_W-1:0];
    nxt.num = {d.num[aluq_pkg::NUM_W-2:0], 1'b0};
    nxt.quo = {d.quo[aluq_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/aluq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aluq_back (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire aluq_pkg::cell_t         d,
  output logic                         out_valid,
  output logic [aluq_pkg::WORD_W-1:0]  out_result,
  output logic                         out_error
);

  logic [aluq_pkg::WORD_W-1:0] res_next;
  logic                        err_next;
  logic                        ovf;

  assign ovf = |d.quo[aluq_pkg::NUM_W-1:aluq_pkg::WORD_W];

  always_comb begin
    case (d.kind)
      aluq_pkg::KIND_DIV: begin
        res_next = ovf ? '1 : d.quo[aluq_pkg::WORD_W-1:0];
        err_next = ovf;
      end
      aluq_pkg::KIND_STEP: begin
        res_next = (d.quo > aluq_pkg::Q_ONE) ? aluq_pkg::Q_ONE[aluq_pkg::WORD_W-1:0]
                                             : d.quo[aluq_pkg::WORD_W-1:0];
        err_next = 1'b0;
      end
      default: begin
        res_next = d.res;
        err_next = d.err;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid  <= d.valid;
      out_result <= res_next;
      out_error  <= err_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/q8_8_fixed_point_alu.sv @@
// Channel  Dir  Beat fields (low bit first)
// s_*      in   tuser: cmd[1:0]; tdata: operand_a, operand_b, operand_c
// m_*      out  tdata: result; tuser: error
//
// One beat is accepted every cycle while m_tready does not stall the chain; each result
// passes through the operand decode and multiplier register, one cell per quotient bit of
// the 24-bit division chain, then the output register.
// rst is synchronous and clears only the valid bits of the chain.
// A stall on m_tready freezes the whole chain, so s_tready follows it.
`timescale 1ns / 1ps
`default_nettype none

module q8_8_fixed_point_alu (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [47:0] s_tdata,   // operand_a, operand_b, operand_c
  input  wire  [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // result
  output logic [0:0]  m_tuser    // error
);

  aluq_pkg::cell_t stage [0:aluq_pkg::NUM_W];
  logic            adv;

  assign adv      = ~m_tvalid | m_tready;
  assign s_tready = adv;

  aluq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_tvalid),
    .cmd       (s_tuser),
    .operand_a (s_tdata[15:0]),
    .operand_b (s_tdata[31:16]),
    .operand_c (s_tdata[47:32]),
    .q         (stage[0])
  );

  for (genvar i = 0; i < aluq_pkg::NUM_W; i++) begin : g_cell
    aluq_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (stage[i]),
      .q   (stage[i+1])
    );
  end

  aluq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .d          (stage[aluq_pkg::NUM_W]),
    .out_valid  (m_tvalid),
    .out_result (m_tdata),
    .out_error  (m_tuser[0])
  );

endmodule

`default_nettype wire

@@ sv/aluq_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aluq_chk (
  input wire        clk,
  input wire        rst,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata,
  input wire [0:0]  m_tuser
);

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow the output stall");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output beat valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

endmodule

bind q8_8_fixed_point_alu aluq_chk u_aluq_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
